// File: sv/pdll_pkg.sv
// shared types and constants for the pooled doubly linked list
package pdll_pkg;

    localparam int LINK_W = 7;
    localparam int DATA_W = 32;

    localparam logic [LINK_W-1:0] HEAD_MARK = 7'd126;
    localparam logic [LINK_W-1:0] TAIL_MARK = 7'd127;

    typedef enum logic [2:0] {
        K_CLEAR  = 3'd0,
        K_FRONT  = 3'd1,
        K_BACK   = 3'd2,
        K_AT     = 3'd3,
        K_FIND   = 3'd4,
        K_REMOVE = 3'd5,
        K_FWD    = 3'd6,
        K_REV    = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_MISSING  = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef struct packed {
        t_kind                     kind;
        logic signed [DATA_W-1:0]  value;
        logic [LINK_W-1:0]         position;
        logic                      is_insert;
        logic                      is_search;
        logic                      is_list;
    } t_req;

endpackage

// File: sv/pdll_front.sv
// request intake: classifies each request and queues it for the engine
module pdll_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_kind,
    input  logic signed [31:0] i_value,
    input  logic [6:0]        i_position,
    output logic              o_req_valid,
    output pdll_pkg::t_req    o_req,
    input  logic              i_req_pop
);
    import pdll_pkg::*;

    t_req        r_q [2];
    logic        r_wp, n_wp;
    logic        r_rp, n_rp;
    logic [1:0]  r_cnt, n_cnt;
    t_req        w_req;
    logic        w_push;

    always_comb begin
        w_req.kind      = t_kind'(i_kind);
        w_req.value     = i_value;
        w_req.position  = i_position;
        w_req.is_insert = (w_req.kind == K_FRONT) || (w_req.kind == K_BACK)
                          || (w_req.kind == K_AT);
        w_req.is_search = (w_req.kind == K_FIND) || (w_req.kind == K_REMOVE);
        w_req.is_list   = (w_req.kind == K_FWD) || (w_req.kind == K_REV);
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = ~r_wp;
        end
        if (i_req_pop) begin
            n_rp = ~r_rp;
        end
        if (w_push && !i_req_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && i_req_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: sv/pdll_back.sv
// list engine: node pool memories, link walking and result register
module pdll_back #(
    parameter int POOL_NODES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  pdll_pkg::t_req    i_req,
    output logic              o_req_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic signed [31:0] o_item,
    output logic [6:0]        o_place,
    output logic [6:0]        o_length,
    output logic [1:0]        o_status,
    output logic              o_last
);
    import pdll_pkg::*;

    localparam int IDX_W = (POOL_NODES > 2) ? $clog2(POOL_NODES) : 1;
    localparam logic [LINK_W-1:0] POOL_CAP = LINK_W'(POOL_NODES);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RD     = 7'b0000010,
        S_CHK    = 7'b0000100,
        S_LINK   = 7'b0001000,
        S_FIX    = 7'b0010000,
        S_UNLINK = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    logic signed [DATA_W-1:0] mem_val  [POOL_NODES];
    logic [LINK_W-1:0]        mem_next [POOL_NODES];
    logic [LINK_W-1:0]        mem_prev [POOL_NODES];

    t_state            r_state, n_state;
    t_req              r_req, n_req;
    logic [LINK_W-1:0] r_first, n_first;
    logic [LINK_W-1:0] r_last_l, n_last_l;
    logic [LINK_W-1:0] r_used, n_used;
    logic [LINK_W-1:0] r_count, n_count;
    logic [LINK_W-1:0] r_cur, n_cur;
    logic [LINK_W-1:0] r_i, n_i;
    logic [LINK_W-1:0] r_p, n_p;
    logic [LINK_W-1:0] r_nx, n_nx;
    logic [LINK_W-1:0] r_rplace, n_rplace;
    t_status           r_rstatus, n_rstatus;

    logic signed [DATA_W-1:0] r_rd_val;
    logic [LINK_W-1:0]        r_rd_next;
    logic [LINK_W-1:0]        r_rd_prev;

    logic                     r_ovalid, n_ovalid;
    logic signed [DATA_W-1:0] r_item, n_item;
    logic [LINK_W-1:0]        r_place, n_place;
    logic [LINK_W-1:0]        r_len, n_len;
    t_status                  r_status, n_status;
    logic                     r_olast, n_olast;

    logic                     w_val_we, w_next_we, w_prev_we;
    logic [IDX_W-1:0]         w_val_addr, w_next_addr, w_prev_addr;
    logic [LINK_W-1:0]        w_next_data, w_prev_data;
    logic                     w_out_free;
    logic [IDX_W-1:0]         w_cur_idx;

    assign w_out_free = !r_ovalid || !i_stall;
    assign w_cur_idx  = r_cur[IDX_W-1:0];
    assign o_req_pop  = (r_state == S_IDLE) && i_req_valid;

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_first   = r_first;
        n_last_l  = r_last_l;
        n_used    = r_used;
        n_count   = r_count;
        n_cur     = r_cur;
        n_i       = r_i;
        n_p       = r_p;
        n_nx      = r_nx;
        n_rplace  = r_rplace;
        n_rstatus = r_rstatus;
        n_ovalid  = r_ovalid && i_stall;
        n_item    = r_item;
        n_place   = r_place;
        n_len     = r_len;
        n_status  = r_status;
        n_olast   = r_olast;
        w_val_we    = 1'b0;
        w_next_we   = 1'b0;
        w_prev_we   = 1'b0;
        w_val_addr  = r_used[IDX_W-1:0];
        w_next_addr = r_used[IDX_W-1:0];
        w_prev_addr = r_used[IDX_W-1:0];
        w_next_data = r_nx;
        w_prev_data = r_p;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req     = i_req;
                    n_rplace  = '0;
                    n_rstatus = ST_OK;
                    n_state   = S_OUT;
                    n_cur     = r_first;
                    n_i       = 7'd1;
                    if (i_req.kind == K_CLEAR) begin
                        n_first  = TAIL_MARK;
                        n_last_l = HEAD_MARK;
                        n_used   = '0;
                        n_count  = '0;
                    end else if (i_req.is_insert) begin
                        if (r_used >= POOL_CAP) begin
                            n_rstatus = ST_FULL;
                        end else if (i_req.kind == K_FRONT) begin
                            n_p     = HEAD_MARK;
                            n_nx    = r_first;
                            n_state = S_LINK;
                        end else if (i_req.kind == K_BACK) begin
                            n_p     = r_last_l;
                            n_nx    = TAIL_MARK;
                            n_state = S_LINK;
                        end else if (i_req.position == '0 ||
                                     {1'b0, i_req.position} > ({1'b0, r_count} + 8'd1)) begin
                            n_rstatus = ST_RANGE;
                        end else if (i_req.position == 7'd1) begin
                            n_p     = HEAD_MARK;
                            n_nx    = r_first;
                            n_state = S_LINK;
                        end else begin
                            n_state = S_RD;
                        end
                    end else if (i_req.is_search) begin
                        if (r_count == '0) begin
                            n_rstatus = ST_MISSING;
                        end else begin
                            n_state = S_RD;
                        end
                    end else begin
                        if (r_count != '0) begin
                            n_cur   = (i_req.kind == K_FWD) ? r_first : r_last_l;
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_req.is_insert) begin
                    if (r_i == r_req.position - 7'd1) begin
                        n_p     = r_cur;
                        n_nx    = r_rd_next;
                        n_state = S_LINK;
                    end else begin
                        n_cur   = r_rd_next;
                        n_i     = r_i + 7'd1;
                        n_state = S_RD;
                    end
                end else if (r_req.is_search) begin
                    if (r_rd_val == r_req.value) begin
                        if (r_req.kind == K_FIND) begin
                            n_rplace = r_i;
                            n_state  = S_OUT;
                        end else begin
                            n_p     = r_rd_prev;
                            n_nx    = r_rd_next;
                            n_state = S_UNLINK;
                        end
                    end else if (r_i == r_count) begin
                        n_rstatus = ST_MISSING;
                        n_state   = S_OUT;
                    end else begin
                        n_cur   = r_rd_next;
                        n_i     = r_i + 7'd1;
                        n_state = S_RD;
                    end
                end else if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_item   = r_rd_val;
                    n_place  = (r_req.kind == K_FWD) ? r_i : (r_count - r_i + 7'd1);
                    n_len    = r_count;
                    n_status = ST_OK;
                    n_olast  = (r_i == r_count);
                    if (r_i == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cur   = (r_req.kind == K_FWD) ? r_rd_next : r_rd_prev;
                        n_i     = r_i + 7'd1;
                        n_state = S_RD;
                    end
                end
            end
            S_LINK: begin
                w_val_we  = 1'b1;
                w_next_we = 1'b1;
                w_prev_we = 1'b1;
                n_state   = S_FIX;
            end
            S_FIX: begin
                if (r_p == HEAD_MARK) begin
                    n_first = r_used;
                end else begin
                    w_next_we   = 1'b1;
                    w_next_addr = r_p[IDX_W-1:0];
                    w_next_data = r_used;
                end
                if (r_nx == TAIL_MARK) begin
                    n_last_l = r_used;
                end else begin
                    w_prev_we   = 1'b1;
                    w_prev_addr = r_nx[IDX_W-1:0];
                    w_prev_data = r_used;
                end
                n_used  = r_used + 7'd1;
                n_count = r_count + 7'd1;
                n_state = S_OUT;
            end
            S_UNLINK: begin
                if (r_p == HEAD_MARK) begin
                    n_first = r_nx;
                end else begin
                    w_next_we   = 1'b1;
                    w_next_addr = r_p[IDX_W-1:0];
                    w_next_data = r_nx;
                end
                if (r_nx == TAIL_MARK) begin
                    n_last_l = r_p;
                end else begin
                    w_prev_we   = 1'b1;
                    w_prev_addr = r_nx[IDX_W-1:0];
                    w_prev_data = r_p;
                end
                n_count = r_count - 7'd1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_item   = '0;
                    n_place  = r_rplace;
                    n_len    = r_count;
                    n_status = r_rstatus;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // node pool
    always_ff @(posedge i_clk) begin
        if (w_val_we) begin
            mem_val[w_val_addr] <= r_req.value;
        end
        r_rd_val <= mem_val[w_cur_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_next_we) begin
            mem_next[w_next_addr] <= w_next_data;
        end
        r_rd_next <= mem_next[w_cur_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_prev_we) begin
            mem_prev[w_prev_addr] <= w_prev_data;
        end
        r_rd_prev <= mem_prev[w_cur_idx];
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_cur    <= n_cur;
        r_i      <= n_i;
        r_p      <= n_p;
        r_nx     <= n_nx;
        r_rplace <= n_rplace;
        r_item   <= n_item;
        r_place  <= n_place;
        r_len    <= n_len;
        r_olast  <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_first   <= TAIL_MARK;
            r_last_l  <= HEAD_MARK;
            r_used    <= '0;
            r_count   <= '0;
            r_rstatus <= ST_OK;
            r_status  <= ST_OK;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_first   <= n_first;
            r_last_l  <= n_last_l;
            r_used    <= n_used;
            r_count   <= n_count;
            r_rstatus <= n_rstatus;
            r_status  <= n_status;
            r_ovalid  <= n_ovalid;
        end
    end

    assign o_valid  = r_ovalid;
    assign o_item   = r_item;
    assign o_place  = r_place;
    assign o_length = r_len;
    assign o_status = r_status;
    assign o_last   = r_olast;

endmodule

// File: sv/pooled_doubly_linked_list.sv
// Ordered list of signed 32-bit values kept in a pool of POOL_NODES nodes linked both
// ways between head and tail sentinels. A two-entry request queue sits in front of the
// list engine, so a new request is taken while the engine still works. Clear goes
// straight to its result; front and back insert write the new node, then fix the
// neighbours' links; find, remove, positional insert and the listings walk the nodes,
// each a registered pool memory read, then a compare. Listings give one result per
// element, last marked on the final one. Removed nodes stay taken until a clear.
module pooled_doubly_linked_list #(
    parameter int POOL_NODES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_value,
    input  logic [6:0]         i_position,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_item,
    output logic [6:0]         o_place,
    output logic [6:0]         o_length,
    output logic [1:0]         o_status,
    output logic               o_last
);
    import pdll_pkg::*;

    logic w_req_valid;
    t_req w_req;
    logic w_req_pop;

    pdll_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .i_position  (i_position),
        .o_req_valid (w_req_valid),
        .o_req       (w_req),
        .i_req_pop   (w_req_pop)
    );

    pdll_back #(
        .POOL_NODES (POOL_NODES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_req_pop   (w_req_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item),
        .o_place     (o_place),
        .o_length    (o_length),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_length <= 7'(POOL_NODES)))
        else $error("length above pool size");

    a_multi_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_status == ST_OK))
        else $error("non-final result with error status");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_place == '0 && o_item == '0))
        else $error("error result carries data");

endmodule
